// ===== src/xbr_pkg.sv =====
// Shared types and constants for the XMODEM block receiver.
// Used by every module under src except xbr_ram; no dependencies of its own.
`default_nettype none

package xbr_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int IDX_W = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLOCK_BYTES - 1);

    localparam logic [7:0] SOH = 8'd1;
    localparam logic [7:0] EOT = 8'd3;
    localparam logic [7:0] CAN = 8'd7;
    localparam logic [7:0] ACK = 8'd1;
    localparam logic [7:0] NAK = 8'd2;

    localparam logic OP_START = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic       to_sender;
        logic [7:0] out_byte;
        logic       last;
    } result_t;

    typedef enum logic [2:0] {
        ST_HEADER,
        ST_BLKNUM,
        ST_INVNUM,
        ST_DATA,
        ST_SUM,
        ST_DRAIN_RD,
        ST_DRAIN_WR,
        ST_ACK
    } state_t;

    typedef enum logic [1:0] {
        OSEL_NAK,
        OSEL_ACK,
        OSEL_DATA
    } out_sel_t;

    // controller -> datapath
    typedef struct packed {
        logic     clr_frame;
        logic     store_byte;
        logic     rd_issue;
        logic     idx_inc;
        logic     load_out;
        out_sel_t out_sel;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_soh;
        logic sum_match;
        logic idx_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== src/xbr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
`default_nettype none

module xbr_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== src/xbr_dpath.sv =====
// Datapath: byte index, running sum, block RAM and the result register.
// Depends on xbr_pkg and xbr_ram.
`default_nettype none

module xbr_dpath (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [7:0]       rx_byte,
    input  wire xbr_pkg::cmd_t    cmd,
    output xbr_pkg::sts_t         sts,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output xbr_pkg::result_t      result
);
    import xbr_pkg::*;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       sum_reg, sum_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_data_reg, out_data_next;
    logic [7:0]       rd_data;
    logic             out_free;

    xbr_ram #(
        .WIDTH (8),
        .DEPTH (BLOCK_BYTES)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.store_byte),
        .wr_addr (idx_reg),
        .wr_data (rx_byte),
        .rd_en   (cmd.rd_issue),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    assign out_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        idx_next = idx_reg;
        sum_next = sum_reg;
        if (cmd.clr_frame)
        begin
            idx_next = '0;
            sum_next = '0;
        end
        else if (cmd.store_byte)
        begin
            idx_next = idx_reg + 1'b1;
            sum_next = sum_reg + rx_byte;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && result_stall;
        out_data_next  = out_data_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
            case (cmd.out_sel)
                OSEL_ACK:  out_data_next = '{to_sender: 1'b1, out_byte: ACK, last: 1'b1};
                OSEL_DATA: out_data_next = '{to_sender: 1'b0, out_byte: rd_data, last: 1'b0};
                default:   out_data_next = '{to_sender: 1'b1, out_byte: NAK, last: 1'b1};
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign sts.is_soh    = (rx_byte == SOH);
    assign sts.sum_match = (rx_byte == sum_reg);
    assign sts.idx_last  = (idx_reg == LAST_IDX);
    assign sts.out_free  = out_free;

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

endmodule

`default_nettype wire

// ===== src/xbr_ctrl.sv =====
// Frame controller: tracks the frame phase and drives datapath commands.
// Depends on xbr_pkg.
`default_nettype none

module xbr_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    input  wire logic          operation,
    output logic               item_stall,
    input  wire xbr_pkg::sts_t sts,
    output xbr_pkg::cmd_t      cmd
);
    import xbr_pkg::*;

    state_t state_reg, state_next;
    logic   ready;
    logic   accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HEADER;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '{default: '0, out_sel: OSEL_NAK};
        ready      = 1'b0;

        case (state_reg)
            ST_HEADER, ST_BLKNUM, ST_INVNUM, ST_DATA, ST_SUM:
            begin
                ready = sts.out_free;
            end
            default:
            begin
                ready = 1'b0;
            end
        endcase

        accept = item_valid && ready;

        if (accept && operation == OP_START)
        begin
            cmd.clr_frame = 1'b1;
            cmd.load_out  = 1'b1;
            cmd.out_sel   = OSEL_NAK;
            state_next    = ST_HEADER;
        end
        else
        begin
            case (state_reg)
                ST_BLKNUM:
                begin
                    if (accept)
                    begin
                        state_next = ST_INVNUM;
                    end
                end
                ST_INVNUM:
                begin
                    if (accept)
                    begin
                        cmd.clr_frame = 1'b1;
                        state_next    = ST_DATA;
                    end
                end
                ST_DATA:
                begin
                    if (accept)
                    begin
                        cmd.store_byte = 1'b1;
                        if (sts.idx_last)
                        begin
                            state_next = ST_SUM;
                        end
                    end
                end
                ST_SUM:
                begin
                    if (accept)
                    begin
                        // index restarts at zero and walks the store on a good sum
                        cmd.clr_frame = 1'b1;
                        if (sts.sum_match)
                        begin
                            state_next = ST_DRAIN_RD;
                        end
                        else
                        begin
                            cmd.load_out = 1'b1;
                            cmd.out_sel  = OSEL_NAK;
                            state_next   = ST_HEADER;
                        end
                    end
                end
                ST_DRAIN_RD:
                begin
                    cmd.rd_issue = 1'b1;
                    state_next   = ST_DRAIN_WR;
                end
                ST_DRAIN_WR:
                begin
                    if (sts.out_free)
                    begin
                        cmd.load_out = 1'b1;
                        cmd.out_sel  = OSEL_DATA;
                        if (sts.idx_last)
                        begin
                            cmd.clr_frame = 1'b1;
                            state_next    = ST_ACK;
                        end
                        else
                        begin
                            cmd.idx_inc = 1'b1;
                            state_next  = ST_DRAIN_RD;
                        end
                    end
                end
                ST_ACK:
                begin
                    if (sts.out_free)
                    begin
                        cmd.load_out = 1'b1;
                        cmd.out_sel  = OSEL_ACK;
                        state_next   = ST_HEADER;
                    end
                end
                default:
                begin
                    // header position; EOT, CAN and junk all answer NAK
                    if (accept)
                    begin
                        cmd.clr_frame = 1'b1;
                        if (sts.is_soh)
                        begin
                            state_next = ST_BLKNUM;
                        end
                        else
                        begin
                            cmd.load_out = 1'b1;
                            cmd.out_sel  = OSEL_NAK;
                            state_next   = ST_HEADER;
                        end
                    end
                end
            endcase
        end
    end

    assign item_stall = !ready;

endmodule

`default_nettype wire

// ===== src/xmodem_block_receiver_core.sv =====
// Top level of the XMODEM block receiver: controller plus datapath.
// Depends on xbr_pkg, xbr_ctrl, xbr_dpath (and xbr_ram below it).
//
//   channel  | direction | handshake                   | payload
//   item     | in        | item_valid / item_stall     | item   (operation, rx_byte)
//   result   | out       | result_valid / result_stall | result (to_sender, out_byte, last)
//
// Any item is taken only while the result register is free (empty, or its
// transfer completes in the same cycle).
// With no result stall a good block drains before the next byte is taken:
// each stored byte costs a registered RAM read plus a load.
// A stalled result holds the result register and stalls the item side.
// Reset (rst_n low, asynchronous) returns to the header phase; store contents
// are not cleared.
`default_nettype none

module xmodem_block_receiver_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire xbr_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output xbr_pkg::result_t      result
);
    import xbr_pkg::*;

    cmd_t cmd;
    sts_t sts;

    xbr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .operation  (item.operation),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    xbr_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_byte      (item.rx_byte),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

// ===== src/xbr_checker.sv =====
// Port-level checks for the XMODEM block receiver, bound to the top level.
// Depends on xbr_pkg.
`default_nettype none

module xbr_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             item_stall,
    input wire logic             result_valid,
    input wire logic             result_stall,
    input wire xbr_pkg::result_t result
);
    import xbr_pkg::*;

    // a pending result that is held back must hold the item side too
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |-> item_stall)
        else $error("item taken while result register is blocked");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.to_sender |-> !result.last)
        else $error("data byte flagged as last");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.to_sender |->
            result.last && (result.out_byte == ACK || result.out_byte == NAK))
        else $error("bad reply to sender");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("stalled result dropped");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("stalled result changed");

endmodule

bind xmodem_block_receiver_core xbr_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire

// ===== tb/xmodem_block_receiver_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for xmodem_block_receiver_core: drives framed and broken
// byte streams and checks each result transfer against an in-bench frame predictor.
// Depends on xbr_pkg and the RTL under src.

module xmodem_block_receiver_core_tb;
    import xbr_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_WAIT   = 2 * BLOCK_BYTES + 8;
    localparam int RANDOM_ITEMS = 300;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    // predictor copy of the receiver state
    state_t     rx_phase = ST_HEADER;
    int         rx_index = 0;
    logic [7:0] rx_sum = '0;
    logic [7:0] rx_block [BLOCK_BYTES];
    result_t    outbound_q[$];

    int err_count = 0;
    int cycle_count = 0;
    int items_sent = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int stall_left = 0;

    xmodem_block_receiver_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int idle_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 24);
        return $urandom_range(1, 3);
    endfunction

    task automatic report(input string what);
        err_count++;
        $display("%0t: %s", $time, what);
    endtask

    task automatic push_reply(input logic to_sender, input logic [7:0] b, input logic last);
        result_t r;
        r.to_sender = to_sender;
        r.out_byte  = b;
        r.last      = last;
        outbound_q.push_back(r);
    endtask

    task automatic frame_restart();
        rx_phase = ST_HEADER;
        rx_index = 0;
        rx_sum   = '0;
    endtask

    // Advance the predictor by one accepted item and queue what it owes.
    task automatic receiver_step(input logic op, input logic [7:0] b);
        if (op == OP_START)
        begin
            frame_restart();
            push_reply(1'b1, NAK, 1'b1);
            return;
        end
        case (rx_phase)
            ST_BLKNUM:
                rx_phase = ST_INVNUM;
            ST_INVNUM:
            begin
                rx_phase = ST_DATA;
                rx_index = 0;
                rx_sum   = '0;
            end
            ST_DATA:
            begin
                rx_block[rx_index] = b;
                rx_sum = rx_sum + b;
                rx_index++;
                if (rx_index >= BLOCK_BYTES)
                    rx_phase = ST_SUM;
            end
            ST_SUM:
            begin
                if (b == rx_sum)
                begin
                    for (int i = 0; i < BLOCK_BYTES; i++)
                        push_reply(1'b0, rx_block[i], 1'b0);
                    push_reply(1'b1, ACK, 1'b1);
                end
                else
                    push_reply(1'b1, NAK, 1'b1);
                frame_restart();
            end
            default:
            begin
                // EOT and CAN fall in here too: session over, fresh NAK
                if (b == SOH)
                begin
                    rx_phase = ST_BLKNUM;
                    rx_index = 0;
                    rx_sum   = '0;
                end
                else
                begin
                    frame_restart();
                    push_reply(1'b1, NAK, 1'b1);
                end
            end
        endcase
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (outbound_q.size() == 0)
        begin
            report($sformatf("unexpected result to_sender=%b out_byte=%02h last=%b",
                             got.to_sender, got.out_byte, got.last));
            return;
        end
        want = outbound_q.pop_front();
        if (got.to_sender !== want.to_sender)
            report($sformatf("to_sender got %b want %b", got.to_sender, want.to_sender));
        if (got.out_byte !== want.out_byte)
            report($sformatf("out_byte got %02h want %02h", got.out_byte, want.out_byte));
        if (got.last !== want.last)
            report($sformatf("last got %b want %b", got.last, want.last));
    endtask

    // Result side: checks each transfer, random stalls plus requested long holds.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            check_result(result);
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            stall_left  = LONG_HOLD;
        end
        else if (stall_left == 0 && $urandom_range(0, 99) < stall_pct)
            stall_left = idle_len();
        result_stall <= (stall_left > 0);
        if (stall_left > 0)
            stall_left--;
    end

    task automatic send_item(input logic op, input logic [7:0] b);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < send_idle_pct)
            gap = idle_len();
        if (gap > 0)
        begin
            item_valid     <= 1'b0;
            item.operation <= 1'($urandom);
            item.rx_byte   <= 8'($urandom);
            repeat (gap) @(posedge clk);
        end
        item_valid     <= 1'b1;
        item.operation <= op;
        item.rx_byte   <= b;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        items_sent++;
        receiver_step(op, b);
    endtask

    // One full frame; alt_fill alternates 00/FF data bytes instead of random ones.
    task automatic send_frame(input bit good_sum, input bit alt_fill);
        logic [7:0] blk;
        logic [7:0] sum;
        logic [7:0] d;
        blk = 8'($urandom);
        sum = '0;
        send_item(OP_BYTE, SOH);
        send_item(OP_BYTE, blk);
        send_item(OP_BYTE, ($urandom_range(0, 3) == 0) ? 8'($urandom) : ~blk);
        for (int i = 0; i < BLOCK_BYTES; i++)
        begin
            d = alt_fill ? ((i % 2 == 0) ? 8'h00 : 8'hFF) : 8'($urandom);
            sum = sum + d;
            send_item(OP_BYTE, d);
        end
        if (!good_sum)
            sum = sum + 8'($urandom_range(1, 255));
        send_item(OP_BYTE, sum);
    endtask

    task automatic test_header_codes();
        send_idle_pct = 0;
        stall_pct     = 0;
        send_item(OP_START, 8'hFF);     // payload ignored on a start
        send_item(OP_BYTE, EOT);
        send_item(OP_BYTE, CAN);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, 8'h00);
    endtask

    task automatic test_start_mid_frame();
        send_item(OP_BYTE, SOH);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, 8'hA5);
        send_item(OP_START, 8'h00);
    endtask

    task automatic test_good_block();
        send_frame(1'b1, 1'b1);
    endtask

    task automatic test_bad_checksum();
        send_idle_pct = 15;
        stall_pct     = 15;
        send_frame(1'b0, 1'b0);
    endtask

    task automatic test_random_sessions(input int n_items);
        int first;
        int kind;
        int cut;
        first = items_sent;
        while (items_sent - first < n_items)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                case ($urandom_range(0, 2))
                    0: send_idle_pct = 0;
                    1: send_idle_pct = 15;
                    default: send_idle_pct = 40;
                endcase
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    default: stall_pct = 30;
                endcase
            end
            kind = $urandom_range(0, 99);
            if (kind < 65)
                send_frame($urandom_range(0, 3) != 0, $urandom_range(0, 9) == 0);
            else if (kind < 73)
                send_item(OP_START, 8'($urandom));
            else if (kind < 87)
            begin
                case ($urandom_range(0, 2))
                    0: send_item(OP_BYTE, EOT);
                    1: send_item(OP_BYTE, CAN);
                    default: send_item(OP_BYTE, 8'($urandom));
                endcase
            end
            else
            begin
                // truncated frame, sometimes cut short by a start
                cut = $urandom_range(1, BLOCK_BYTES + 2);
                send_item(OP_BYTE, SOH);
                repeat (cut)
                    send_item(OP_BYTE, 8'($urandom));
                if ($urandom_range(0, 1) == 0)
                    send_item(OP_START, 8'($urandom));
            end
        end
    endtask

    // Receiver holds off while the sender keeps offering back to back.
    task automatic test_result_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_requests++;
        send_frame(1'b1, 1'b0);
        send_frame(1'b1, 1'b0);
        send_item(OP_START, 8'($urandom));
    endtask

    task automatic finish_run();
        item_valid <= 1'b0;
        stall_pct = 10;
        while (outbound_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (err_count == 0 && outbound_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_header_codes();
        test_start_mid_frame();
        test_good_block();
        test_bad_checksum();
        test_random_sessions(RANDOM_ITEMS);
        test_result_backpressure();
        test_random_sessions(20);
        finish_run();
    end

endmodule
